// ===== hw/rtl/fhip_pkg.sv =====
// Package for the forwarded-header address extractor.
// Holds the header text, character codes, phase and status types.
// No dependencies.
package fhip_pkg;

  // Header text "X-Forwarded-For: "
  localparam int unsigned HDR_LEN = 17;

  // Default search window in payload bytes
  localparam int unsigned WINDOW_DEF = 256;

  // Address characters consumed at most
  localparam logic [3:0] MAX_ADDR_CHARS = 4'd15;

  // Character codes
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;
  localparam logic [7:0] CHAR_DOT  = 8'd46;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OFFS_W   = 8;
  localparam int unsigned CHARS_W  = 4;
  localparam int unsigned OUT_W    = 48;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_PARSE  = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_PARSED    = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_CUT_OFF   = 2'd2
  } status_t;

  // Header character at position idx
  function automatic logic [7:0] hdr_char(input int unsigned idx);
    logic [7:0] c;
    case (idx)
      0:       c = 8'd88;   // X
      1:       c = 8'd45;   // -
      2:       c = 8'd70;   // F
      3:       c = 8'd111;  // o
      4:       c = 8'd114;  // r
      5:       c = 8'd119;  // w
      6:       c = 8'd97;   // a
      7:       c = 8'd114;  // r
      8:       c = 8'd100;  // d
      9:       c = 8'd101;  // e
      10:      c = 8'd100;  // d
      11:      c = 8'd45;   // -
      12:      c = 8'd70;   // F
      13:      c = 8'd111;  // o
      14:      c = 8'd114;  // r
      15:      c = 8'd58;   // :
      16:      c = 8'd32;   // space
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Shift a finished octet into the address
  function automatic logic [31:0] fold(input logic [31:0] addr, input logic [7:0] oct);
    return {addr[23:0], oct};
  endfunction

endpackage

// ===== hw/rtl/fhip_cell.sv =====
// One stage of the header match chain: holds one payload byte,
// hands it to the next stage and compares it to its header character.
// No dependencies.
module fhip_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] din,
  input  logic [7:0] match_char,
  output logic [7:0] dout,
  output logic       hit
);

  logic [7:0] byte_r;

  // byte storage, moves one place per accepted transaction
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= din;
    end
  end

  assign dout = byte_r;
  assign hit  = (byte_r == match_char);

endmodule

// ===== hw/rtl/forwarded_header_ip_extractor.sv =====
// Scans TCP payload bytes (one per transaction, tlast on the packet's final byte) for the
// first "X-Forwarded-For: " header within the first WINDOW - 1 bytes and parses the dotted IPv4
// address after it. Each packet gives exactly one result transaction: the address (status 0),
// header not found (status 1) or address cut off by the window or the packet end (status 2).
// The block takes one byte per clock cycle: the header is matched by a row of sixteen byte
// cells plus the incoming byte, and the address is built by a small per-byte update. A
// result sits in one output register; while it is stalled by out_tready the input is held
// off, otherwise input and output proceed in the same cycle. out_tvalid is registered and rises
// in the cycle after the byte that settles a packet's result is accepted.
module forwarded_header_ip_extractor #(
  parameter int unsigned WINDOW = fhip_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] address, [33:32] status, [41:34] address_offset
);

  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned NCELLS = fhip_pkg::HDR_LEN - 1;

  logic                            out_valid_r;
  logic [fhip_pkg::OUT_W-1:0]      out_data_r;

  // Transaction handshake
  logic in_acc;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Header match chain
  logic [7:0] chain_d [NCELLS];
  logic [7:0] chain_q [NCELLS];
  logic [NCELLS-1:0] cell_hit;
  logic hdr_match;

  genvar g;
  generate
    for (g = 0; g < NCELLS; g++) begin : g_cell
      if (g == NCELLS - 1) begin : g_tail
        assign chain_d[g] = in_tdata;
      end else begin : g_mid
        assign chain_d[g] = chain_q[g+1];
      end
      fhip_cell u_cell (
        .clk        (clk),
        .shift_en   (in_acc),
        .din        (chain_d[g]),
        .match_char (fhip_pkg::hdr_char(g)),
        .dout       (chain_q[g]),
        .hit        (cell_hit[g])
      );
    end
  endgenerate

  assign hdr_match = (&cell_hit) && (in_tdata == fhip_pkg::hdr_char(NCELLS));

  // Per-packet state
  fhip_pkg::phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [7:0]                   octet_r, octet_nxt;
  logic [31:0]                  addr_r, addr_nxt;
  logic [fhip_pkg::CHARS_W-1:0] chars_r, chars_nxt;
  logic [fhip_pkg::OFFS_W-1:0]  start_r, start_nxt;

  // Result of this byte
  logic                         emit;
  logic [31:0]                  emit_addr;
  fhip_pkg::status_t            emit_status;
  logic [fhip_pkg::OFFS_W-1:0]  emit_offs;

  // Parse helpers
  logic                         is_digit, is_dot, ended;
  logic [7:0]                   oct_digit, oct_a;
  logic [31:0]                  addr_a;
  logic [fhip_pkg::CHARS_W-1:0] chars_inc;
  logic [CNT_W-1:0]             idx_inc;

  always_comb begin
    is_digit  = (in_tdata >= fhip_pkg::CHAR_ZERO) && (in_tdata <= fhip_pkg::CHAR_NINE);
    is_dot    = (in_tdata == fhip_pkg::CHAR_DOT);
    oct_digit = {octet_r[4:0], 3'b000} + {octet_r[6:0], 1'b0} + (in_tdata - fhip_pkg::CHAR_ZERO);
    chars_inc = chars_r + 1'b1;
    idx_inc   = count_r + 1'b1;

    // character update: digit accumulates, anything else folds
    if (is_digit) begin
      oct_a  = oct_digit;
      addr_a = addr_r;
    end else begin
      oct_a  = '0;
      addr_a = fhip_pkg::fold(addr_r, octet_r);
    end
    ended = !(is_digit || is_dot);

    phase_nxt   = phase_r;
    count_nxt   = count_r;
    octet_nxt   = octet_r;
    addr_nxt    = addr_r;
    chars_nxt   = chars_r;
    start_nxt   = start_r;
    emit        = 1'b0;
    emit_addr   = '0;
    emit_status = fhip_pkg::ST_PARSED;
    emit_offs   = '0;

    if (count_r < CNT_W'(WINDOW)) begin
      count_nxt = idx_inc;
    end

    case (phase_r)
      fhip_pkg::PH_SEARCH: begin
        if (count_r >= CNT_W'(fhip_pkg::HDR_LEN - 1) && count_r <= CNT_W'(WINDOW - 2)
            && hdr_match) begin
          phase_nxt = fhip_pkg::PH_PARSE;
          start_nxt = idx_inc[fhip_pkg::OFFS_W-1:0];
          octet_nxt = '0;
          addr_nxt  = '0;
          chars_nxt = '0;
          if (in_tlast) begin
            emit        = 1'b1;
            emit_status = fhip_pkg::ST_CUT_OFF;
            emit_offs   = idx_inc[fhip_pkg::OFFS_W-1:0];
          end
        end else if (in_tlast || count_r >= CNT_W'(WINDOW - 2)) begin
          emit        = 1'b1;
          emit_status = fhip_pkg::ST_NOT_FOUND;
        end
      end
      fhip_pkg::PH_PARSE: begin
        chars_nxt = chars_inc;
        octet_nxt = oct_a;
        addr_nxt  = addr_a;
        // length limit folds the octet once more
        if (!ended && chars_inc >= fhip_pkg::MAX_ADDR_CHARS) begin
          addr_nxt = fhip_pkg::fold(addr_a, oct_a);
          ended    = 1'b1;
        end
        if (ended) begin
          emit        = 1'b1;
          emit_addr   = addr_nxt;
          emit_status = fhip_pkg::ST_PARSED;
          emit_offs   = start_r;
        end else if (in_tlast || count_r >= CNT_W'(WINDOW - 1)) begin
          emit        = 1'b1;
          emit_status = fhip_pkg::ST_CUT_OFF;
          emit_offs   = start_r;
        end
      end
      default: begin
      end
    endcase

    // packet end clears per-packet state
    if (in_tlast) begin
      phase_nxt = fhip_pkg::PH_SEARCH;
      count_nxt = '0;
      octet_nxt = '0;
      addr_nxt  = '0;
      chars_nxt = '0;
      start_nxt = '0;
    end else if (emit) begin
      phase_nxt = fhip_pkg::PH_DONE;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fhip_pkg::PH_SEARCH;
      count_r <= '0;
      octet_r <= '0;
      addr_r  <= '0;
      chars_r <= '0;
      start_r <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      octet_r <= octet_nxt;
      addr_r  <= addr_nxt;
      chars_r <= chars_nxt;
      start_r <= start_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_data_r <= {6'b000000, emit_offs, emit_status, emit_addr};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sim/tb.sv =====
// Testbench for forwarded_header_ip_extractor: drives payload packets and checks each result
// transaction against a behavioural predictor held in a small scoreboard class.
// Depends on fhip_pkg and the extractor RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WIN       = fhip_pkg::WINDOW_DEF;
  localparam int unsigned CYC_LIMIT = 150000;
  localparam logic [8*fhip_pkg::HDR_LEN-1:0] HDR_STR = "X-Forwarded-For: ";
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_COMMA = 8'd44;

  typedef struct packed {
    logic [31:0]       address;
    fhip_pkg::status_t status;
    logic [7:0]        offset;
  } ipx_result_t;

  // Predicts the extractor result per payload byte and keeps results not yet seen
  class addr_scoreboard;
    logic [7:0]       recent [fhip_pkg::HDR_LEN];
    int unsigned      nbytes;
    fhip_pkg::phase_t ph;
    logic [7:0]       octet;
    logic [31:0]      addr;
    int unsigned      nchars;
    logic [7:0]       start;
    ipx_result_t      expected [$];
    int               errors;

    function new();
      errors = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      foreach (recent[i]) recent[i] = 8'd0;
      nbytes = 0;
      ph     = fhip_pkg::PH_SEARCH;
      octet  = 8'd0;
      addr   = 32'd0;
      nchars = 0;
      start  = 8'd0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void push(logic [31:0] a, fhip_pkg::status_t s, logic [7:0] o);
      ipx_result_t r;
      r.address = a;
      r.status  = s;
      r.offset  = o;
      expected.push_back(r);
    endfunction

    // One accepted payload byte
    function void note_byte(logic [7:0] c, logic lst);
      int unsigned idx;
      bit          fired;
      bit          ended;
      bit          match;
      idx   = nbytes;
      fired = 1'b0;
      if (nbytes < WIN) nbytes++;
      case (ph)
        fhip_pkg::PH_SEARCH: begin
          for (int i = 0; i < fhip_pkg::HDR_LEN - 1; i++) recent[i] = recent[i + 1];
          recent[fhip_pkg::HDR_LEN - 1] = c;
          match = 1'b1;
          for (int i = 0; i < fhip_pkg::HDR_LEN; i++)
            if (recent[i] != HDR_STR[8*(fhip_pkg::HDR_LEN-1-i) +: 8]) match = 1'b0;
          if (idx >= fhip_pkg::HDR_LEN - 1 && idx <= WIN - 2 && match) begin
            ph     = fhip_pkg::PH_PARSE;
            start  = 8'(idx + 1);
            octet  = 8'd0;
            addr   = 32'd0;
            nchars = 0;
            if (lst) begin
              push(32'd0, fhip_pkg::ST_CUT_OFF, start);
              fired = 1'b1;
            end
          end else if (lst || idx >= WIN - 2) begin
            push(32'd0, fhip_pkg::ST_NOT_FOUND, 8'd0);
            fired = 1'b1;
          end
        end
        fhip_pkg::PH_PARSE: begin
          ended = 1'b0;
          nchars++;
          if (c >= fhip_pkg::CHAR_ZERO && c <= fhip_pkg::CHAR_NINE) begin
            octet = octet * 8'd10 + (c - fhip_pkg::CHAR_ZERO);
          end else if (c == fhip_pkg::CHAR_DOT) begin
            addr  = {addr[23:0], octet};
            octet = 8'd0;
          end else begin
            addr  = {addr[23:0], octet};
            ended = 1'b1;
          end
          // length limit: fold whatever octet is pending
          if (!ended && nchars >= fhip_pkg::MAX_ADDR_CHARS) begin
            addr  = {addr[23:0], octet};
            ended = 1'b1;
          end
          if (ended) begin
            push(addr, fhip_pkg::ST_PARSED, start);
            fired = 1'b1;
          end else if (lst || idx >= WIN - 1) begin
            push(32'd0, fhip_pkg::ST_CUT_OFF, start);
            fired = 1'b1;
          end
        end
        default: ;
      endcase
      if (lst) clear_packet();
      else if (fired) ph = fhip_pkg::PH_DONE;
    endfunction

    // One accepted result transaction
    function void check_result(logic [47:0] d);
      ipx_result_t e;
      if (expected.size() == 0) begin
        $error("unexpected result transaction: tdata %h", d);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (d[31:0] !== e.address) begin
        $error("address: expected %h, got %h", e.address, d[31:0]);
        errors++;
      end
      if (d[33:32] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, d[33:32]);
        errors++;
      end
      if (d[41:34] !== e.offset) begin
        $error("address_offset: expected %0d, got %0d", e.offset, d[41:34]);
        errors++;
      end
      if (d[47:42] !== 6'd0) begin
        $error("tdata padding: expected 0, got %h", d[47:42]);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  addr_scoreboard sb;
  logic [7:0]  pkt [$];
  int unsigned in_idle_pct  = 24;
  int unsigned out_idle_pct = 24;
  int unsigned sent_bytes   = 0;
  int unsigned npkts        = 0;
  int unsigned cycles       = 0;

  forwarded_header_ip_extractor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random back-pressure and checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Payload byte transaction with random gap in front
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned n;
    n = 0;
    while ($urandom_range(99) < in_idle_pct) n++;
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, lst);
    sent_bytes++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    pkt.delete();
    npkts++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endtask

  task automatic add_random(input int unsigned n);
    repeat (n) pkt.push_back(8'($urandom_range(255)));
  endtask

  // Header, optionally with one byte spoilt
  task automatic add_header(input bit spoil);
    int unsigned pos;
    pos = $urandom_range(fhip_pkg::HDR_LEN - 1);
    for (int i = 0; i < fhip_pkg::HDR_LEN; i++)
      if (spoil && i == pos) pkt.push_back(8'($urandom_range(255)));
      else pkt.push_back(HDR_STR[8*(fhip_pkg::HDR_LEN-1-i) +: 8]);
  endtask

  // Dotted address text, up to five octets of up to three digits
  task automatic add_address();
    int unsigned nocts;
    nocts = $urandom_range(1, 5);
    for (int k = 0; k < nocts; k++) begin
      repeat ($urandom_range(0, 3))
        pkt.push_back(fhip_pkg::CHAR_ZERO + 8'($urandom_range(9)));
      if (k != nocts - 1) pkt.push_back(fhip_pkg::CHAR_DOT);
    end
    case ($urandom_range(3))
      0: pkt.push_back(CHAR_CR);
      1: pkt.push_back(CHAR_SPACE);
      2: pkt.push_back(8'($urandom_range(255)));
      default: ;
    endcase
  endtask

  // Digit and dot soup to hit the length limit
  task automatic add_digit_run(input int unsigned n);
    repeat (n)
      if ($urandom_range(3) == 0) pkt.push_back(fhip_pkg::CHAR_DOT);
      else pkt.push_back(fhip_pkg::CHAR_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned kind;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed packets
    add_header(0); add_text("192.168.1.1"); pkt.push_back(CHAR_CR); add_text("\nrest");
    send_packet();
    add_text("GET / HTTP/1.1"); send_packet();
    pkt.push_back(8'h00); send_packet();
    pkt.push_back(8'hFF); send_packet();
    // header as the final bytes of the packet
    add_header(0); send_packet();
    add_header(0); add_text("10.0.0"); send_packet();
    add_text("ab"); add_header(0); add_text("255.255.255.255 x"); send_packet();
    // dot as the fifteenth character
    add_header(0); add_text("12.3.4.5.6.7.8.9"); send_packet();
    add_header(0); add_text("999.1000.7.300,"); send_packet();
    add_header(0); pkt.push_back(CHAR_CR); add_text("tail"); send_packet();
    // partial header, then the real one, then a second one that must be ignored
    add_text("X-Forwarded-Fo"); add_header(0); add_text("8.8.4.4;"); add_header(0);
    add_text("1.1.1.1 "); send_packet();
    add_text("x-forwarded-for: 1.2.3.4 "); send_packet();
    add_header(0); add_text("1.2.3.4"); send_packet();
    // header ending at the last allowed offset, digit at the window edge
    add_random(WIN - 1 - fhip_pkg::HDR_LEN); add_header(0); add_text("5.6"); send_packet();
    add_random(WIN - 1 - fhip_pkg::HDR_LEN); add_header(0); pkt.push_back(CHAR_SPACE);
    add_random(5); send_packet();
    // header one byte too late
    add_random(WIN - fhip_pkg::HDR_LEN); add_header(0); add_text("9.9.9.9 "); send_packet();
    add_random(20); pkt.push_back(CHAR_COMMA); send_packet();

    drain();

    // Random packets
    while (sent_bytes < 1200 || npkts < 28) begin
      if (npkts >= 19 && npkts < 26) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 24;
        out_idle_pct = 24;
      end
      kind = $urandom_range(99);
      if (kind < 55) begin
        add_random($urandom_range(0, 12)); add_header(0); add_address();
        add_random($urandom_range(0, 6));
      end else if (kind < 65) begin
        add_random($urandom_range(0, 6)); add_header(1); add_address();
        add_random($urandom_range(0, 4));
      end else if (kind < 76) begin
        add_random($urandom_range(1, 40));
      end else if (kind < 87) begin
        add_header(0); add_digit_run($urandom_range(10, 20));
        add_random($urandom_range(0, 3));
      end else if (kind < 91) begin
        add_random($urandom_range(225, 245)); add_header(0); add_address();
        add_random($urandom_range(0, 30));
      end else begin
        add_random($urandom_range(0, 4)); add_header(0);
        repeat ($urandom_range(0, 6))
          pkt.push_back(fhip_pkg::CHAR_ZERO + 8'($urandom_range(9)));
      end
      send_packet();
      if (npkts == 26) drain();
    end

    // Wait for the last results, then a short settle
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
